[hdl/imr_pkg.sv]
// Shared constants, types and a helper function of the icosphere midpoint refiner.
package imr_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = COORD_BITS - 3;
  localparam int PROBE_LIMIT   = 8;
  localparam int IDX_W         = 10;
  localparam int VCNT_W        = IDX_W + 1;
  localparam int TBL_W         = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W       = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int SUM_W         = COORD_BITS + 1;
  localparam int SQ_W          = 2 * COORD_BITS;
  localparam int ROOT_W        = COORD_BITS + 1;
  localparam int NUM_W         = COORD_BITS + FRAC_BITS;
  localparam int DCNT_W        = $clog2(NUM_W);
  localparam int HASH_MUL      = 37;
  localparam int STATUS_W      = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REFINE = 1'b1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_STORE_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_UNWRITTEN  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ZERO_VEC   = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [2:0][COORD_BITS-1:0]   vtx_t;

  typedef struct packed {
    logic                valid;
    idx_t                lo;
    idx_t                hi;
    idx_t                mid;
  } tbl_ent_t;

  typedef struct packed {
    logic                kind;
    idx_t                vertex_index;
    coord_t              unit_x;
    coord_t              unit_y;
    coord_t              unit_z;
    idx_t                tri_a;
    idx_t                tri_b;
    idx_t                tri_c;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_EDGE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_RD_P,
    ST_RD_Q,
    ST_SUM,
    ST_N_MAG,
    ST_N_SHIFT,
    ST_N_SQ,
    ST_N_SQRT,
    ST_N_DSET,
    ST_N_DIV,
    ST_N_DONE,
    ST_TRI,
    ST_EMIT
  } state_t;

  function automatic logic signed [SUM_W-1:0] sext_coord(logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

endpackage

[hdl/imr_in_if.sv]
// Input channel of the icosphere midpoint refiner.
interface imr_in_if;
  import imr_pkg::*;
  logic   valid;
  logic   ready;
  logic   op;
  coord_t load_x;
  coord_t load_y;
  coord_t load_z;
  idx_t   first_corner;
  idx_t   second_corner;
  idx_t   third_corner;
  modport source (output valid, op, load_x, load_y, load_z,
                  first_corner, second_corner, third_corner, input ready);
  modport sink (input valid, op, load_x, load_y, load_z,
                first_corner, second_corner, third_corner, output ready);
endinterface

[hdl/imr_out_if.sv]
// Result channel of the icosphere midpoint refiner.
interface imr_out_if;
  import imr_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  idx_t                vertex_index;
  coord_t              unit_x;
  coord_t              unit_y;
  coord_t              unit_z;
  idx_t                tri_a;
  idx_t                tri_b;
  idx_t                tri_c;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, kind, vertex_index, unit_x, unit_y, unit_z,
                  tri_a, tri_b, tri_c, status, last, input ready);
  modport sink (input valid, kind, vertex_index, unit_x, unit_y, unit_z,
                tri_a, tri_b, tri_c, status, last, output ready);
endinterface

[hdl/icosphere_midpoint_refiner.sv]
// Icosphere midpoint refiner: vertex store, midpoint table and normalizer.
// The block takes items on in_chan and delivers results on out_chan, both
// valid/ready channels where a transfer happens when valid and ready are high.
// A load item normalizes one vertex, stores it and returns one result.
// A refine item returns up to three new vertices and then four child triangles;
// the final result of every item has last set.
// One normalization runs a magnitude step, shift steps, squaring steps,
// square-root steps, divide steps for each of the three components and a
// store step.
// A load item keeps the block busy until its result enters the output register.
// A refine item checks its corners, then per edge probes the midpoint table and,
// on a miss, sums the two end vertices and runs the sum through the shared
// bit-serial normalizer; then it emits the four triangles. One item is worked
// on at a time.
// After reset the block sweeps every midpoint table entry invalid and
// holds in_chan.ready low meanwhile.
// Results go through an output register; when the receiver stalls, the
// pending result waits and work stops at the next result until it is taken.
module icosphere_midpoint_refiner (
  input logic clk,
  input logic rst_n,
  imr_in_if.sink    in_chan,
  imr_out_if.source out_chan
);
  import imr_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [TBL_W-1:0]  clr_r, clr_nxt;
  idx_t              c_r [3], c_nxt [3];
  idx_t              mids_r [3], mids_nxt [3];
  logic [VCNT_W-1:0] vcount_r, vcount_nxt;
  logic [1:0]        e_r, e_nxt, t_r, t_nxt, k_r, k_nxt, dk_r, dk_nxt;
  logic [PROBE_W-1:0] i_r, i_nxt;
  idx_t              lo_r, lo_nxt, hi_r, hi_nxt;
  logic [TBL_W-1:0]  h0_r, h0_nxt, free_r, free_nxt;
  logic              is_load_r, is_load_nxt;
  logic signed [SUM_W-1:0] nin_r [3], nin_nxt [3];
  logic              neg_r [3], neg_nxt [3];
  logic [COORD_BITS-1:0] mag_r [3], mag_nxt [3];
  logic [COORD_BITS-1:0] m_r, m_nxt;
  logic [SQ_W-1:0]   acc_r, acc_nxt, sqv_r, sqv_nxt, sqres_r, sqres_nxt;
  logic [SQ_W-1:0]   sqbit_r, sqbit_nxt;
  logic [ROOT_W-1:0] n_r, n_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt, quo_r, quo_nxt;
  logic [ROOT_W-1:0] rem_r, rem_nxt;
  coord_t            unit_r [3], unit_nxt [3];
  res_t              pend_r, pend_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  vtx_t              vs_mem [MAX_VERTICES];
  vtx_t              vs_q_r, vs_wd;
  logic              vs_we;
  idx_t              vs_wa, vs_ra;
  tbl_ent_t          tbl_mem [TABLE_ENTRIES];
  tbl_ent_t          tbl_q_r, tbl_wd;
  logic              tbl_we;
  logic [TBL_W-1:0]  tbl_wa, tbl_ra;

  logic              in_xfer, emit_go;
  idx_t              p_idx, q_idx, lo_c, hi_c;
  logic [COORD_BITS-1:0] mag_c [3];
  logic [COORD_BITS-1:0] m_c;
  logic [SQ_W-1:0]   prod_c, try_c;
  logic [ROOT_W:0]   remx_c;
  logic              qbit_c;
  logic [NUM_W-1:0]  quo_c;
  logic [TBL_W-1:0]  probe_c;
  res_t              vres_c;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer = in_chan.valid && in_chan.ready;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_r.kind;
  assign out_chan.vertex_index = out_r.vertex_index;
  assign out_chan.unit_x       = out_r.unit_x;
  assign out_chan.unit_y       = out_r.unit_y;
  assign out_chan.unit_z       = out_r.unit_z;
  assign out_chan.tri_a        = out_r.tri_a;
  assign out_chan.tri_b        = out_r.tri_b;
  assign out_chan.tri_c        = out_r.tri_c;
  assign out_chan.status       = out_r.status;
  assign out_chan.last         = out_r.last;

  always_comb begin
    p_idx = c_r[e_r];
    q_idx = (e_r == 2'd2) ? c_r[0] : c_r[e_r + 2'd1];
    lo_c = (p_idx < q_idx) ? p_idx : q_idx;
    hi_c = (p_idx < q_idx) ? q_idx : p_idx;
    probe_c = h0_r + TBL_W'(i_r);
    for (int j = 0; j < 3; j++) begin
      mag_c[j] = nin_r[j][SUM_W-1] ? COORD_BITS'(-nin_r[j]) : COORD_BITS'(nin_r[j]);
    end
    m_c = mag_c[0];
    if (mag_c[1] > m_c) m_c = mag_c[1];
    if (mag_c[2] > m_c) m_c = mag_c[2];
    prod_c = mag_r[k_r] * mag_r[k_r];
    try_c = sqres_r + sqbit_r;
    remx_c = {rem_r, num_r[NUM_W-1]};
    qbit_c = (remx_c >= {1'b0, n_r});
    quo_c = {quo_r[NUM_W-2:0], qbit_c};
    vres_c = '0;
    vres_c.kind = KIND_VERTEX;
    vres_c.vertex_index = vcount_r[IDX_W-1:0];
    vres_c.unit_x = unit_r[0];
    vres_c.unit_y = unit_r[1];
    vres_c.unit_z = unit_r[2];
    vres_c.status = STAT_OK;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (clr_r == TBL_W'(TABLE_ENTRIES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.op == OP_REFINE) state_nxt = ST_CHECK;
          else if (vcount_r >= VCNT_W'(MAX_VERTICES)) state_nxt = ST_EMIT;
          else state_nxt = ST_N_MAG;
        end
      end
      ST_CHECK: begin
        if (c_r[0] >= vcount_r || c_r[1] >= vcount_r || c_r[2] >= vcount_r)
          state_nxt = ST_EMIT;
        else state_nxt = ST_EDGE;
      end
      ST_EDGE:      state_nxt = (e_r == 2'd3) ? ST_TRI : ST_PROBE_RD;
      ST_PROBE_RD:  state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (!tbl_q_r.valid) begin
          state_nxt = (vcount_r >= VCNT_W'(MAX_VERTICES)) ? ST_EMIT : ST_RD_P;
        end else if (tbl_q_r.lo == lo_r && tbl_q_r.hi == hi_r) begin
          state_nxt = ST_EDGE;
        end else if (i_r == PROBE_W'(PROBE_LIMIT - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PROBE_RD;
        end
      end
      ST_RD_P:      state_nxt = ST_RD_Q;
      ST_RD_Q:      state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_N_MAG;
      ST_N_MAG:     state_nxt = (m_c == '0) ? ST_EMIT : ST_N_SHIFT;
      ST_N_SHIFT:   if (m_r > COORD_BITS'(1 << (COORD_BITS - 2))) state_nxt = ST_N_SQ;
      ST_N_SQ:      if (k_r == 2'd2) state_nxt = ST_N_SQRT;
      ST_N_SQRT:    if (sqbit_r == SQ_W'(1)) state_nxt = ST_N_DSET;
      ST_N_DSET:    state_nxt = ST_N_DIV;
      ST_N_DIV: begin
        if (dcnt_r == DCNT_W'(NUM_W - 1))
          state_nxt = (dk_r == 2'd2) ? ST_N_DONE : ST_N_DSET;
      end
      ST_N_DONE:    state_nxt = ST_EMIT;
      ST_TRI:       state_nxt = ST_EMIT;
      ST_EMIT:      if (emit_go) state_nxt = ret_r;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt = ret_r;
    clr_nxt = clr_r;
    c_nxt = c_r;
    mids_nxt = mids_r;
    vcount_nxt = vcount_r;
    e_nxt = e_r;
    t_nxt = t_r;
    k_nxt = k_r;
    dk_nxt = dk_r;
    i_nxt = i_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    h0_nxt = h0_r;
    free_nxt = free_r;
    is_load_nxt = is_load_r;
    nin_nxt = nin_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    m_nxt = m_r;
    acc_nxt = acc_r;
    sqv_nxt = sqv_r;
    sqres_nxt = sqres_r;
    sqbit_nxt = sqbit_r;
    n_nxt = n_r;
    dcnt_nxt = dcnt_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    unit_nxt = unit_r;
    pend_nxt = pend_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    vs_we = 1'b0;
    vs_wa = vcount_r[IDX_W-1:0];
    vs_wd = {unit_r[2], unit_r[1], unit_r[0]};
    vs_ra = p_idx;
    tbl_we = 1'b0;
    tbl_wa = free_r;
    tbl_wd = '{valid: 1'b1, lo: lo_r, hi: hi_r, mid: vcount_r[IDX_W-1:0]};
    tbl_ra = probe_c;

    if (emit_go) begin
      out_nxt = pend_r;
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        tbl_wa = clr_r;
        tbl_wd = '0;
        clr_nxt = clr_r + TBL_W'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          c_nxt[0] = in_chan.first_corner;
          c_nxt[1] = in_chan.second_corner;
          c_nxt[2] = in_chan.third_corner;
          nin_nxt[0] = sext_coord(in_chan.load_x);
          nin_nxt[1] = sext_coord(in_chan.load_y);
          nin_nxt[2] = sext_coord(in_chan.load_z);
          is_load_nxt = 1'b1;
          pend_nxt = '0;
          pend_nxt.kind = KIND_VERTEX;
          pend_nxt.status = STAT_STORE_FULL;
          pend_nxt.last = 1'b1;
          ret_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        e_nxt = 2'd0;
        is_load_nxt = 1'b0;
        pend_nxt = '0;
        pend_nxt.kind = KIND_TRI;
        pend_nxt.status = STAT_UNWRITTEN;
        pend_nxt.last = 1'b1;
        ret_nxt = ST_IDLE;
      end
      ST_EDGE: begin
        t_nxt = 2'd0;
        i_nxt = '0;
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        h0_nxt = TBL_W'(lo_c * HASH_MUL) + TBL_W'(hi_c);
      end
      ST_PROBE_RD: begin
        free_nxt = probe_c;
      end
      ST_PROBE_CHK: begin
        pend_nxt = '0;
        pend_nxt.kind = KIND_TRI;
        pend_nxt.last = 1'b1;
        ret_nxt = ST_IDLE;
        if (!tbl_q_r.valid) begin
          pend_nxt.status = STAT_STORE_FULL;
        end else if (tbl_q_r.lo == lo_r && tbl_q_r.hi == hi_r) begin
          mids_nxt[e_r] = tbl_q_r.mid;
          e_nxt = e_r + 2'd1;
        end else begin
          pend_nxt.status = STAT_TABLE_FULL;
          i_nxt = i_r + PROBE_W'(1);
        end
      end
      ST_RD_Q: begin
        vs_ra = q_idx;
        for (int j = 0; j < 3; j++) nin_nxt[j] = sext_coord(vs_q_r[j]);
      end
      ST_SUM: begin
        for (int j = 0; j < 3; j++) nin_nxt[j] = nin_r[j] + sext_coord(vs_q_r[j]);
      end
      ST_N_MAG: begin
        for (int j = 0; j < 3; j++) begin
          mag_nxt[j] = mag_c[j];
          neg_nxt[j] = nin_r[j][SUM_W-1];
        end
        m_nxt = m_c;
        k_nxt = 2'd0;
        acc_nxt = '0;
        pend_nxt = '0;
        pend_nxt.kind = is_load_r ? KIND_VERTEX : KIND_TRI;
        pend_nxt.status = STAT_ZERO_VEC;
        pend_nxt.last = 1'b1;
        ret_nxt = ST_IDLE;
      end
      ST_N_SHIFT: begin
        if (m_r <= COORD_BITS'(1 << (COORD_BITS - 2))) begin
          m_nxt = m_r << 1;
          for (int j = 0; j < 3; j++) mag_nxt[j] = mag_r[j] << 1;
        end
      end
      ST_N_SQ: begin
        acc_nxt = acc_r + prod_c;
        k_nxt = k_r + 2'd1;
        sqv_nxt = acc_r + prod_c;
        sqres_nxt = '0;
        sqbit_nxt = SQ_W'(1) << (SQ_W - 2);
      end
      ST_N_SQRT: begin
        if (sqv_r >= try_c) begin
          sqv_nxt = sqv_r - try_c;
          sqres_nxt = (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_nxt = sqres_r >> 1;
        end
        sqbit_nxt = sqbit_r >> 2;
        n_nxt = sqres_nxt[ROOT_W-1:0];
        dk_nxt = 2'd0;
      end
      ST_N_DSET: begin
        num_nxt = (NUM_W'(mag_r[dk_r]) << FRAC_BITS) + NUM_W'(n_r >> 1);
        rem_nxt = '0;
        quo_nxt = '0;
        dcnt_nxt = '0;
      end
      ST_N_DIV: begin
        rem_nxt = qbit_c ? ROOT_W'(remx_c - {1'b0, n_r}) : ROOT_W'(remx_c);
        num_nxt = num_r << 1;
        quo_nxt = quo_c;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
          unit_nxt[dk_r] = neg_r[dk_r] ? -coord_t'(quo_c[COORD_BITS-1:0])
                                       : coord_t'(quo_c[COORD_BITS-1:0]);
          dk_nxt = dk_r + 2'd1;
        end
      end
      ST_N_DONE: begin
        vs_we = 1'b1;
        pend_nxt = vres_c;
        vcount_nxt = vcount_r + VCNT_W'(1);
        if (is_load_r) begin
          pend_nxt.last = 1'b1;
          ret_nxt = ST_IDLE;
        end else begin
          tbl_we = 1'b1;
          mids_nxt[e_r] = vcount_r[IDX_W-1:0];
          e_nxt = e_r + 2'd1;
          ret_nxt = ST_EDGE;
        end
      end
      ST_TRI: begin
        pend_nxt = '0;
        pend_nxt.kind = KIND_TRI;
        pend_nxt.status = STAT_OK;
        case (t_r)
          2'd0: begin
            pend_nxt.tri_a = c_r[0];
            pend_nxt.tri_b = mids_r[0];
            pend_nxt.tri_c = mids_r[2];
          end
          2'd1: begin
            pend_nxt.tri_a = c_r[1];
            pend_nxt.tri_b = mids_r[1];
            pend_nxt.tri_c = mids_r[0];
          end
          2'd2: begin
            pend_nxt.tri_a = c_r[2];
            pend_nxt.tri_b = mids_r[2];
            pend_nxt.tri_c = mids_r[1];
          end
          default: begin
            pend_nxt.tri_a = mids_r[0];
            pend_nxt.tri_b = mids_r[1];
            pend_nxt.tri_c = mids_r[2];
          end
        endcase
        pend_nxt.last = (t_r == 2'd3);
        ret_nxt = (t_r == 2'd3) ? ST_IDLE : ST_TRI;
        t_nxt = t_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_wa] <= vs_wd;
    vs_q_r <= vs_mem[vs_ra];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_q_r <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ret_r <= ST_IDLE;
      clr_r <= '0;
      vcount_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      clr_r <= clr_nxt;
      vcount_r <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    mids_r <= mids_nxt;
    e_r <= e_nxt;
    t_r <= t_nxt;
    k_r <= k_nxt;
    dk_r <= dk_nxt;
    i_r <= i_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    h0_r <= h0_nxt;
    free_r <= free_nxt;
    is_load_r <= is_load_nxt;
    nin_r <= nin_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    m_r <= m_nxt;
    acc_r <= acc_nxt;
    sqv_r <= sqv_nxt;
    sqres_r <= sqres_nxt;
    sqbit_r <= sqbit_nxt;
    n_r <= n_nxt;
    dcnt_r <= dcnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    unit_r <= unit_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
  end

endmodule

[tb/tb_icosphere_midpoint_refiner.sv]
// Self-checking testbench of the icosphere midpoint refiner with a predictor and random traffic.
`timescale 1ns / 100ps

module tb_icosphere_midpoint_refiner;
  import imr_pkg::*;

  typedef struct {
    logic   op;
    coord_t x, y, z;
    idx_t   ca, cb, cc;
    bit     hold;
    int     nres;
  } item_t;

  logic clk;
  logic rst_n;
  imr_in_if  in_chan ();
  imr_out_if out_chan ();

  icosphere_midpoint_refiner i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  item_t  pending_items[$];
  res_t   planned_results[$];
  res_t   expected_results[$];
  item_t  driven_item;
  int     errors;
  int     accepted;
  int     received;

  longint vert_store [MAX_VERTICES][3];
  int     vert_count;
  bit     slot_valid [TABLE_ENTRIES];
  int     slot_lo [TABLE_ENTRIES];
  int     slot_hi [TABLE_ENTRIES];
  int     slot_mid [TABLE_ENTRIES];
  int     tri_pool[$][3];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void plan_result(res_t r);
    planned_results.insert(planned_results.size(), r);
  endfunction

  function automatic void add_tri(int a, int b, int c);
    int t[3];
    t = '{a, b, c};
    tri_pool.insert(tri_pool.size(), t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_scale(input longint vin[3], output longint vout[3]);
    longint unsigned mag[3];
    longint unsigned m, s, n, q;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vin[i] < 0 ? -vin[i] : vin[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 1'b0;
    while ((m << 1) <= (64'd1 << (COORD_BITS - 1))) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC_BITS) + n / 2) / n;
      vout[i] = vin[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic res_t make_result(logic kind, int vi, longint v[3], int a, int b, int c,
                                       logic [STATUS_W-1:0] st);
    res_t r;
    r.kind = kind;
    r.vertex_index = idx_t'(vi);
    r.unit_x = coord_t'(v[0]);
    r.unit_y = coord_t'(v[1]);
    r.unit_z = coord_t'(v[2]);
    r.tri_a = idx_t'(a);
    r.tri_b = idx_t'(b);
    r.tri_c = idx_t'(c);
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

  // Advances the refiner state by one item and queues the results it causes.
  function automatic int refine_results(input item_t it);
    longint zero[3];
    longint raw[3];
    longint u[3];
    int c[3];
    int mids[3];
    int n, p, q, lo, hi, h0, j, free_slot;
    bit hit;
    logic [STATUS_W-1:0] err;
    res_t r;
    zero = '{0, 0, 0};
    n = 0;
    if (it.op == OP_LOAD) begin
      raw = '{longint'(it.x), longint'(it.y), longint'(it.z)};
      if (vert_count >= MAX_VERTICES) begin
        r = make_result(KIND_VERTEX, 0, zero, 0, 0, 0, STAT_STORE_FULL);
      end else if (!unit_scale(raw, u)) begin
        r = make_result(KIND_VERTEX, 0, zero, 0, 0, 0, STAT_ZERO_VEC);
      end else begin
        vert_store[vert_count] = u;
        r = make_result(KIND_VERTEX, vert_count, u, 0, 0, 0, STAT_OK);
        vert_count++;
      end
      r.last = 1'b1;
      plan_result(r);
      return 1;
    end
    c = '{int'(it.ca), int'(it.cb), int'(it.cc)};
    for (int i = 0; i < 3; i++) begin
      if (c[i] >= vert_count) begin
        r = make_result(KIND_TRI, 0, zero, 0, 0, 0, STAT_UNWRITTEN);
        r.last = 1'b1;
        plan_result(r);
        return 1;
      end
    end
    for (int e = 0; e < 3; e++) begin
      p = c[e];
      q = c[(e + 1) % 3];
      lo = p < q ? p : q;
      hi = p < q ? q : p;
      h0 = (lo * HASH_MUL + hi) % TABLE_ENTRIES;
      free_slot = -1;
      hit = 1'b0;
      err = STAT_OK;
      for (int i = 0; i < PROBE_LIMIT; i++) begin
        j = (h0 + i) % TABLE_ENTRIES;
        if (!slot_valid[j]) begin
          free_slot = j;
          break;
        end
        if (slot_lo[j] == lo && slot_hi[j] == hi) begin
          hit = 1'b1;
          mids[e] = slot_mid[j];
          break;
        end
      end
      if (hit) continue;
      if (free_slot < 0) begin
        err = STAT_TABLE_FULL;
      end else if (vert_count >= MAX_VERTICES) begin
        err = STAT_STORE_FULL;
      end else begin
        for (int i = 0; i < 3; i++) raw[i] = vert_store[p][i] + vert_store[q][i];
        if (!unit_scale(raw, u)) err = STAT_ZERO_VEC;
      end
      if (err != STAT_OK) begin
        r = make_result(KIND_TRI, 0, zero, 0, 0, 0, err);
        r.last = 1'b1;
        plan_result(r);
        return n + 1;
      end
      vert_store[vert_count] = u;
      slot_valid[free_slot] = 1'b1;
      slot_lo[free_slot] = lo;
      slot_hi[free_slot] = hi;
      slot_mid[free_slot] = vert_count;
      mids[e] = vert_count;
      plan_result(make_result(KIND_VERTEX, vert_count, u, 0, 0, 0, STAT_OK));
      n++;
      vert_count++;
    end
    plan_result(make_result(KIND_TRI, 0, zero, c[0], mids[0], mids[2], STAT_OK));
    plan_result(make_result(KIND_TRI, 0, zero, c[1], mids[1], mids[0], STAT_OK));
    plan_result(make_result(KIND_TRI, 0, zero, c[2], mids[2], mids[1], STAT_OK));
    r = make_result(KIND_TRI, 0, zero, mids[0], mids[1], mids[2], STAT_OK);
    r.last = 1'b1;
    plan_result(r);
    add_tri(c[0], mids[0], mids[2]);
    add_tri(c[1], mids[1], mids[0]);
    add_tri(c[2], mids[2], mids[1]);
    add_tri(mids[0], mids[1], mids[2]);
    return n + 4;
  endfunction

  task automatic queue_load(int x, int y, int z, bit hold = 1'b0);
    item_t it;
    it = '{op: OP_LOAD, x: coord_t'(x), y: coord_t'(y), z: coord_t'(z),
           ca: '0, cb: '0, cc: '0, hold: hold, nres: 0};
    it.nres = refine_results(it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_refine(int a, int b, int c, bit hold = 1'b0);
    item_t it;
    it = '{op: OP_REFINE, x: '0, y: '0, z: '0,
           ca: idx_t'(a), cb: idx_t'(b), cc: idx_t'(c), hold: hold, nres: 0};
    it.nres = refine_results(it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_random_refine();
    int pick;
    int t;
    pick = $urandom_range(99);
    if (pick < 55 && tri_pool.size() > 0) begin
      t = $urandom_range(tri_pool.size() - 1);
      queue_refine(tri_pool[t][0], tri_pool[t][1], tri_pool[t][2]);
    end else if (pick < 92) begin
      queue_refine($urandom_range(vert_count - 1), $urandom_range(vert_count - 1),
                   $urandom_range(vert_count - 1));
    end else begin
      queue_refine($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.op <= OP_LOAD;
      in_chan.load_x <= '0;
      in_chan.load_y <= '0;
      in_chan.load_z <= '0;
      in_chan.first_corner <= '0;
      in_chan.second_corner <= '0;
      in_chan.third_corner <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        for (int i = 0; i < driven_item.nres; i++)
          expected_results.insert(expected_results.size(), planned_results.pop_front());
        accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_items.size() == 0 ||
            (pending_items[0].hold && expected_results.size() != 0) ||
            (!(accepted >= 120 && accepted < 200) && $urandom_range(99) < 27)) begin
          in_chan.valid <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.op <= driven_item.op;
          in_chan.load_x <= driven_item.x;
          in_chan.load_y <= driven_item.y;
          in_chan.load_z <= driven_item.z;
          in_chan.first_corner <= driven_item.ca;
          in_chan.second_corner <= driven_item.cb;
          in_chan.third_corner <= driven_item.cc;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.kind, out_chan.vertex_index, out_chan.unit_x, out_chan.unit_y,
                out_chan.unit_z, out_chan.tri_a, out_chan.tri_b, out_chan.tri_c,
                out_chan.status, out_chan.last};
        received++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result actual %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
      out_chan.ready <= (received >= 400 && received < 600) || $urandom_range(99) >= 27;
    end
  end

  initial begin
    #(64'd40_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    errors = 0;
    accepted = 0;
    received = 0;
    vert_count = 0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    rst_n = 1'b0;

    // The directed part covers the field extremes and the unwritten-corner and zero-vector error paths.
    queue_refine(0, 0, 0);
    queue_load(0, 0, 0);
    queue_load(32767, 32767, 32767);
    queue_load(-32768, -32768, -32768);
    queue_load(8192, 0, 0);
    queue_load(-8192, 0, 0);
    queue_load(0, 1, 0);
    queue_load(0, 0, -1);
    queue_load(-32768, 32767, 1);
    queue_refine(3, 4, 5);
    queue_refine(0, 1, 5);
    queue_refine(5, 4, 3);
    queue_refine(2, 2, 2);
    queue_refine(6, 1023, 0);
    queue_refine(1023, 1023, 1023);
    queue_refine(0, 1, 2, 1'b1);
    queue_refine(6, 5, 6);

    for (int k = 0; k < 270; k++) begin
      if ($urandom_range(99) < 25)
        queue_load($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   k == 150);
      else
        queue_random_refine();
    end
    queue_load(1, 2, 3, 1'b1);
    queue_load(0, 0, 0);
    for (int k = 0; k < 12; k++) queue_random_refine();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
